[rtl/lrro_pkg.sv]
// Package for the LRU replacement order unit: sizes, operation and status codes,
// the command and status structs shared by the controller and datapath, and the
// result struct. No dependencies.
package lrro_pkg;

    localparam int ENTRIES = 16;
    localparam int ID_BITS = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int OP_W    = 2;
    localparam int ST_W    = 3;

    // Result fields packed into m_tdata, padded to whole bytes.
    localparam int M_FIELDS_W = ID_BITS + 1 + ID_BITS + 1 + CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int S_TDATA_W  = ((ID_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TOUCH  = 2'd2,
        OP_PURGE  = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    // Controller to datapath.
    typedef struct packed {
        logic    capture;     // latch key and the lookup of the arriving item
        logic    commit;      // apply the update and load the result register
        logic    drop_en;     // close the gap at the drop position
        logic    drop_head;   // drop position is the least-recent slot
        logic    write_en;    // write the key at the most-recent end
        logic    write_last;  // write at fill-1 (after a drop) rather than at fill
        logic    fill_inc;
        logic    fill_dec;
        logic    victim_en;
        status_t status;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic present;
        logic full;
        logic empty;
    } dp_stat_t;

    typedef struct packed {
        logic [CNT_W-1:0]   fill_count;
        logic               oldest_valid;
        logic [ID_BITS-1:0] oldest_id;
        logic               key_present;
        logic [ID_BITS-1:0] victim_id;
        status_t            status;
    } result_t;

endpackage

[rtl/lru_replacement_order_unit.sv]
// Channel  Ports                      Item contents
// input    s_tvalid/s_tready          s_tuser: op; s_tdata: key
// result   m_tvalid/m_tready          m_tuser: status; m_tdata: result fields
//
// Each item is accepted in S_IDLE, where its key is looked up in all slots at once;
// in S_APPLY the recency stack is shifted or inserted and the result register loaded.
// The update waits while the previous result is still held and not yet taken.
// A new item is accepted while a finished result waits on the output.
// Reset (aresetn, synchronous) empties the store; slot contents are not cleared.
// Top level of the LRU replacement order unit; uses lrro_pkg, lrro_ctrl and
// lrro_datapath.
module lru_replacement_order_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lrro_pkg::S_TDATA_W-1:0]  s_tdata,   // key
    input  logic [lrro_pkg::OP_W-1:0]       s_tuser,   // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // victim_id, key_present, oldest_id, oldest_valid, fill_count, zero padding
    output logic [lrro_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [lrro_pkg::ST_W-1:0]       m_tuser    // status
);

    lrro_pkg::dp_cmd_t  cmd;
    lrro_pkg::dp_stat_t stat;
    lrro_pkg::result_t  result;

    lrro_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op_in    (lrro_pkg::op_t'(s_tuser)),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lrro_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .key_in  (s_tdata[lrro_pkg::ID_BITS-1:0]),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

    assign m_tdata = lrro_pkg::M_TDATA_W'({result.fill_count, result.oldest_valid,
                                           result.oldest_id, result.key_present,
                                           result.victim_id});
    assign m_tuser = result.status;

endmodule

[rtl/lrro_datapath.sv]
// Datapath of the LRU replacement order unit: recency stack of ids, parallel key
// lookup, shift/insert update, fill level and result register. Uses lrro_pkg.
module lrro_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [lrro_pkg::ID_BITS-1:0]   key_in,
    input  lrro_pkg::dp_cmd_t              cmd,
    output lrro_pkg::dp_stat_t             stat,
    output lrro_pkg::result_t              result
);

    logic [lrro_pkg::ID_BITS-1:0] slot_reg  [lrro_pkg::ENTRIES];
    logic [lrro_pkg::ID_BITS-1:0] slot_next [lrro_pkg::ENTRIES];
    logic [lrro_pkg::ID_BITS-1:0] slot_up   [lrro_pkg::ENTRIES];
    logic [lrro_pkg::CNT_W-1:0]   fill_reg, fill_next;
    logic [lrro_pkg::ID_BITS-1:0] key_reg;
    logic [lrro_pkg::IDX_W-1:0]   pos_reg, pos_lookup, drop_pos, wr_idx;
    logic                         present_reg;
    logic [lrro_pkg::ENTRIES-1:0] hit;
    lrro_pkg::result_t            result_reg, result_next;

    // Ids held are always distinct, so at most one lane hits and an OR encode suffices.
    always_comb begin
        pos_lookup = '0;
        for (int i = 0; i < lrro_pkg::ENTRIES; i++) begin
            hit[i] = (lrro_pkg::CNT_W'(i) < fill_reg) && (slot_reg[i] == key_in);
            if (hit[i]) begin
                pos_lookup = pos_lookup | lrro_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < lrro_pkg::ENTRIES - 1; i++) begin
            slot_up[i] = slot_reg[i + 1];
        end
        slot_up[lrro_pkg::ENTRIES-1] = slot_reg[lrro_pkg::ENTRIES-1];
    end

    assign drop_pos = cmd.drop_head ? '0 : pos_reg;
    assign wr_idx   = cmd.write_last ? lrro_pkg::IDX_W'(fill_reg - 1'b1)
                                     : lrro_pkg::IDX_W'(fill_reg);

    always_comb begin
        for (int i = 0; i < lrro_pkg::ENTRIES; i++) begin
            if (cmd.write_en && (lrro_pkg::IDX_W'(i) == wr_idx)) begin
                slot_next[i] = key_reg;
            end else if (cmd.drop_en && (lrro_pkg::IDX_W'(i) >= drop_pos)) begin
                slot_next[i] = slot_up[i];
            end else begin
                slot_next[i] = slot_reg[i];
            end
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (cmd.fill_inc) begin
            fill_next = fill_reg + 1'b1;
        end else if (cmd.fill_dec) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_comb begin
        result_next.status       = cmd.status;
        result_next.victim_id    = cmd.victim_en ? slot_reg[0] : '0;
        result_next.key_present  = present_reg;
        result_next.oldest_valid = (fill_next != '0);
        result_next.oldest_id    = (fill_next != '0) ? slot_next[0] : '0;
        result_next.fill_count   = fill_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cmd.commit) begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            key_reg     <= key_in;
            pos_reg     <= pos_lookup;
            present_reg <= |hit;
        end
        if (cmd.commit) begin
            for (int i = 0; i < lrro_pkg::ENTRIES; i++) begin
                slot_reg[i] <= slot_next[i];
            end
            result_reg <= result_next;
        end
    end

    assign stat.present = present_reg;
    assign stat.full    = (fill_reg == lrro_pkg::CNT_W'(lrro_pkg::ENTRIES));
    assign stat.empty   = (fill_reg == '0);
    assign result       = result_reg;

endmodule

[rtl/lrro_ctrl.sv]
// Controller of the LRU replacement order unit: handshake state machine and
// decoding of each operation into datapath commands. Uses lrro_pkg.
module lrro_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  lrro_pkg::op_t          op_in,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  lrro_pkg::dp_stat_t     stat,
    output lrro_pkg::dp_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    lrro_pkg::op_t op_reg;
    logic          m_tvalid_reg, m_tvalid_next;
    logic          out_free, accept;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd            = '0;
        cmd.status     = lrro_pkg::ST_OK;
        cmd.capture    = accept;
        state_next     = state_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                // The update waits until the result register can take the new item.
                if (out_free) begin
                    cmd.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
                unique case (op_reg)
                    lrro_pkg::OP_ADD: begin
                        if (stat.present) begin
                            cmd.status = lrro_pkg::ST_DUP;
                        end else if (stat.full) begin
                            cmd.status = lrro_pkg::ST_FULL;
                        end else begin
                            cmd.write_en = 1'b1;
                            cmd.fill_inc = 1'b1;
                        end
                    end
                    lrro_pkg::OP_REMOVE: begin
                        if (stat.present) begin
                            cmd.drop_en  = 1'b1;
                            cmd.fill_dec = 1'b1;
                        end else begin
                            cmd.status = lrro_pkg::ST_NOTFOUND;
                        end
                    end
                    lrro_pkg::OP_TOUCH: begin
                        if (stat.present) begin
                            cmd.drop_en    = 1'b1;
                            cmd.write_en   = 1'b1;
                            cmd.write_last = 1'b1;
                        end else begin
                            cmd.status = lrro_pkg::ST_NOTFOUND;
                        end
                    end
                    lrro_pkg::OP_PURGE: begin
                        if (stat.empty) begin
                            cmd.status = lrro_pkg::ST_EMPTY;
                        end else begin
                            cmd.drop_en   = 1'b1;
                            cmd.drop_head = 1'b1;
                            cmd.fill_dec  = 1'b1;
                            cmd.victim_en = 1'b1;
                        end
                    end
                    default: begin
                        cmd.status = lrro_pkg::ST_OK;
                    end
                endcase
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg <= op_in;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

[rtl/lrro_checker.sv]
// Port-level checker for the LRU replacement order unit, bound to the top level.
// Uses lrro_pkg for field positions and codes.
module lrro_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lrro_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [lrro_pkg::ST_W-1:0]       m_tuser
);

    localparam int OLD_LO  = lrro_pkg::ID_BITS + 1;
    localparam int VALID_B = 2 * lrro_pkg::ID_BITS + 1;
    localparam int FILL_LO = 2 * lrro_pkg::ID_BITS + 2;

    logic [lrro_pkg::CNT_W-1:0]   fill;
    logic [lrro_pkg::ID_BITS-1:0] victim;

    assign fill   = m_tdata[FILL_LO +: lrro_pkg::CNT_W];
    assign victim = m_tdata[lrro_pkg::ID_BITS-1:0];

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_oldest_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[VALID_B] == (fill != '0))
                     && (fill <= lrro_pkg::CNT_W'(lrro_pkg::ENTRIES)))
        else $error("fill count and oldest valid disagree");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == lrro_pkg::ST_EMPTY)
        |-> (victim == '0) && (fill == '0)
            && (m_tdata[OLD_LO +: lrro_pkg::ID_BITS] == '0))
        else $error("empty purge reported contents");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == lrro_pkg::ST_OK) || (m_tuser == lrro_pkg::ST_DUP)
                     || (m_tuser == lrro_pkg::ST_NOTFOUND) || (m_tuser == lrro_pkg::ST_FULL)
                     || (m_tuser == lrro_pkg::ST_EMPTY))
        else $error("undefined status code");

endmodule

bind lru_replacement_order_unit lrro_checker u_lrro_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
